@@ rtl/mwee_pkg.sv @@
package mwee_pkg;

    localparam int FRAME_BITS_MAX_DEF = 25;
    localparam int READ_BITS_DEF      = 16;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int SHORT_BITS  = 9;
    localparam int ADDR_LSB    = 3;
    localparam int WORD_LSB    = 9;
    localparam int DELAY_W     = 20;
    localparam int FILL_W      = 25;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_ENABLE  = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_DISABLE = 3'd4;
    localparam logic [2:0] KIND_ERASE   = 3'd5;
    localparam logic [2:0] KIND_FILL    = 3'd6;

    localparam logic [2:0] REG_READ_OP    = 3'd0;
    localparam logic [2:0] REG_WRITE_OP   = 3'd1;
    localparam logic [2:0] REG_ENABLE     = 3'd2;
    localparam logic [2:0] REG_DISABLE    = 3'd3;
    localparam logic [2:0] REG_ERASE      = 3'd4;
    localparam logic [2:0] REG_FILL       = 3'd5;
    localparam logic [2:0] REG_EDGE_DELAY = 3'd6;
    localparam logic [2:0] REG_WRITE_WAIT = 3'd7;

    localparam logic [8:0]         RST_READ_OP    = 9'd3;
    localparam logic [8:0]         RST_WRITE_OP   = 9'd5;
    localparam logic [8:0]         RST_ENABLE     = 9'd25;
    localparam logic [8:0]         RST_DISABLE    = 9'd1;
    localparam logic [8:0]         RST_ERASE      = 9'd9;
    localparam logic [FILL_W-1:0]  RST_FILL       = 25'd17;
    localparam logic [15:0]        RST_EDGE_DELAY = 16'd1;
    localparam logic [DELAY_W-1:0] RST_WRITE_WAIT = 20'd10000;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_CLK_LOW    = 4'd1,
        PH_DATA_LOW   = 4'd2,
        PH_SEL_ON     = 4'd3,
        PH_BIT_DATA   = 4'd4,
        PH_BIT_HI     = 4'd5,
        PH_BIT_LO     = 4'd6,
        PH_RD_HI      = 4'd7,
        PH_RD_SAMPLE  = 4'd8,
        PH_SEL_OFF    = 4'd9,
        PH_WRITE_WAIT = 4'd10
    } t_phase;

    typedef struct packed {
        logic [8:0]         read_op;
        logic [8:0]         write_op;
        logic [8:0]         enable_frame;
        logic [8:0]         disable_frame;
        logic [8:0]         erase_frame;
        logic [FILL_W-1:0]  fill_frame;
        logic [15:0]        edge_delay;
        logic [DELAY_W-1:0] write_wait;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic        is_cmd;
        logic [5:0]  addr;
        logic [15:0] word;
        logic        sin;
    } t_cmd;

    typedef struct packed {
        logic        rejected;
        logic        read_done;
        logic [15:0] read_word;
        logic        busy;
        logic        sel;
        logic        dat;
        logic        clk;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ rtl/mwee_queue.sv @@
module mwee_queue #(
    parameter int DEPTH = mwee_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mwee_pkg::t_cmd  i_item,
    input  logic            i_pop,
    output mwee_pkg::t_cmd  o_item,
    output mwee_pkg::t_qstat o_stat
);
    import mwee_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/mwee_front.sv @@
module mwee_front (
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [mwee_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic [2:0]                          i_tuser,
    input  mwee_pkg::t_qstat                    i_qstat,
    output logic                                o_push,
    output mwee_pkg::t_cmd                      o_item
);
    import mwee_pkg::*;

    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && !i_qstat.full;

    always_comb begin
        o_item.kind   = i_tuser;
        o_item.is_cmd = (i_tuser >= KIND_READ) && (i_tuser <= KIND_FILL);
        o_item.addr   = i_tdata[5:0];
        o_item.word   = i_tdata[21:6];
        o_item.sin    = i_tdata[22];
    end

endmodule

@@ rtl/mwee_back.sv @@
module mwee_back #(
    parameter int FRAME_BITS_MAX = mwee_pkg::FRAME_BITS_MAX_DEF,
    parameter int READ_BITS      = mwee_pkg::READ_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mwee_pkg::t_cfg     i_cfg,
    input  mwee_pkg::t_qstat   i_qstat,
    input  mwee_pkg::t_cmd     i_item,
    output logic               o_pop,
    input  logic               i_tready,
    output logic               o_tvalid,
    output mwee_pkg::t_result  o_result
);
    import mwee_pkg::*;

    localparam int FW      = FRAME_BITS_MAX;
    localparam int WIDE    = (FW > FILL_W) ? FW : FILL_W;
    localparam int CNT_MAX = (FW > READ_BITS) ? FW : READ_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    t_phase             r_phase, n_phase;
    logic [1:0]         r_step, n_step;
    logic [CNT_W-1:0]   r_bits, n_bits;
    logic [FW-1:0]      r_send, n_send;
    logic [15:0]        r_recv, n_recv;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [2:0]         r_kind, n_kind;
    logic               r_clk, n_clk, r_dat, n_dat, r_sel, n_sel;
    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               w_busy, w_act, w_done, w_more;
    logic [1:0]         w_step_inc;
    logic [CNT_W-1:0]   w_bits_dec;
    logic [3:0]         w_idx;
    logic [DELAY_W-1:0] w_d1, w_d2;

    function automatic logic [FW-1:0] frame_of(input logic [2:0] kind,
                                               input logic [1:0] step,
                                               input logic [5:0] addr,
                                               input logic [15:0] word,
                                               input t_cfg cfg);
        logic [WIDE-1:0] f;
        case (kind)
            KIND_READ: begin
                f = WIDE'(cfg.read_op) | (WIDE'(addr) << ADDR_LSB);
            end
            KIND_ENABLE: begin
                f = WIDE'(cfg.enable_frame);
            end
            KIND_WRITE: begin
                f = WIDE'(cfg.write_op) | (WIDE'(addr) << ADDR_LSB)
                    | (WIDE'(word) << WORD_LSB);
            end
            KIND_DISABLE: begin
                f = WIDE'(cfg.disable_frame);
            end
            default: begin
                if (step == 2'd0) begin
                    f = WIDE'(cfg.enable_frame);
                end else if (step == 2'd1) begin
                    f = (kind == KIND_ERASE) ? WIDE'(cfg.erase_frame)
                                             : WIDE'(cfg.fill_frame);
                end else begin
                    f = WIDE'(cfg.disable_frame);
                end
            end
        endcase
        return f[FW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] bits_of(input logic [2:0] kind,
                                                 input logic [1:0] step);
        logic is_long;
        is_long = (kind == KIND_WRITE) || (kind == KIND_FILL && step == 2'd1);
        return is_long ? CNT_W'(FW) : CNT_W'(SHORT_BITS);
    endfunction

    assign o_pop    = !i_qstat.empty && (!r_out_valid || i_tready);
    assign o_tvalid = r_out_valid;
    assign o_result = r_out;

    assign w_busy     = (r_phase != PH_IDLE) || (r_delay != '0);
    assign w_act      = (r_delay == '0);
    assign w_d1       = DELAY_W'(i_cfg.edge_delay);
    assign w_d2       = DELAY_W'({i_cfg.edge_delay, 1'b0});
    assign w_bits_dec = (r_bits != '0) ? CNT_W'(r_bits - 1'b1) : '0;
    assign w_more     = (w_bits_dec != '0);
    assign w_step_inc = 2'(r_step + 2'd1);
    assign w_idx      = 4'(CNT_W'(READ_BITS) - r_bits);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_act) begin
            case (r_phase)
                PH_IDLE:       n_phase = i_item.is_cmd ? PH_CLK_LOW : PH_IDLE;
                PH_CLK_LOW:    n_phase = PH_DATA_LOW;
                PH_DATA_LOW:   n_phase = PH_SEL_ON;
                PH_SEL_ON:     n_phase = PH_BIT_DATA;
                PH_BIT_DATA:   n_phase = PH_BIT_HI;
                PH_BIT_HI:     n_phase = PH_BIT_LO;
                PH_BIT_LO: begin
                    if (w_more) begin
                        n_phase = PH_BIT_DATA;
                    end else if (r_kind == KIND_READ) begin
                        n_phase = PH_RD_HI;
                    end else begin
                        n_phase = PH_SEL_OFF;
                    end
                end
                PH_RD_HI:      n_phase = PH_RD_SAMPLE;
                PH_RD_SAMPLE:  n_phase = w_more ? PH_RD_HI : PH_SEL_OFF;
                PH_SEL_OFF: begin
                    if (r_kind == KIND_WRITE) begin
                        n_phase = PH_WRITE_WAIT;
                    end else if ((r_kind == KIND_ERASE || r_kind == KIND_FILL)
                                 && w_step_inc != 2'd3) begin
                        n_phase = PH_CLK_LOW;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_WRITE_WAIT: n_phase = PH_IDLE;
                default:       n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and pins
    always_comb begin
        n_step  = r_step;
        n_bits  = r_bits;
        n_send  = r_send;
        n_recv  = r_recv;
        n_kind  = r_kind;
        n_clk   = r_clk;
        n_dat   = r_dat;
        n_sel   = r_sel;
        n_delay = w_act ? '0 : DELAY_W'(r_delay - 1'b1);
        w_done  = 1'b0;
        if (w_act) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_item.is_cmd) begin
                        n_kind = i_item.kind;
                        n_step = 2'd0;
                        n_send = frame_of(i_item.kind, 2'd0, i_item.addr,
                                          i_item.word, i_cfg);
                        n_bits = bits_of(i_item.kind, 2'd0);
                        if (i_item.kind == KIND_READ) begin
                            n_recv = '0;
                        end
                    end
                end
                PH_CLK_LOW: begin
                    n_clk   = 1'b0;
                    n_delay = w_d1;
                end
                PH_DATA_LOW: begin
                    n_dat   = 1'b0;
                    n_delay = w_d2;
                end
                PH_SEL_ON: begin
                    n_sel   = 1'b1;
                    n_delay = w_d1;
                end
                PH_BIT_DATA: begin
                    n_dat   = r_send[0];
                    n_send  = r_send >> 1;
                    n_delay = w_d1;
                end
                PH_BIT_HI: begin
                    n_clk   = 1'b1;
                    n_delay = w_d1;
                end
                PH_BIT_LO: begin
                    n_clk = 1'b0;
                    if (w_more) begin
                        n_bits  = w_bits_dec;
                        n_delay = w_d1;
                    end else if (r_kind == KIND_READ) begin
                        n_bits  = CNT_W'(READ_BITS);
                        n_delay = w_d1;
                    end else begin
                        n_bits  = w_bits_dec;
                        n_delay = w_d2;
                    end
                end
                PH_RD_HI: begin
                    n_clk   = 1'b1;
                    n_delay = w_d2;
                end
                PH_RD_SAMPLE: begin
                    n_recv = r_recv | (16'(i_item.sin) << w_idx);
                    n_clk  = 1'b0;
                    n_bits = w_bits_dec;
                    if (w_more) begin
                        n_delay = w_d1;
                    end else begin
                        w_done  = 1'b1;
                        n_delay = w_d2;
                    end
                end
                PH_SEL_OFF: begin
                    n_sel   = 1'b0;
                    n_step  = w_step_inc;
                    n_delay = w_d1;
                    if (r_kind != KIND_WRITE
                        && (r_kind == KIND_ERASE || r_kind == KIND_FILL)
                        && w_step_inc != 2'd3) begin
                        n_send = frame_of(r_kind, w_step_inc, 6'd0, 16'd0, i_cfg);
                        n_bits = bits_of(r_kind, w_step_inc);
                    end
                end
                PH_WRITE_WAIT: begin
                    n_delay = i_cfg.write_wait;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out.clk       = n_clk;
        n_out.dat       = n_dat;
        n_out.sel       = n_sel;
        n_out.busy      = (n_phase != PH_IDLE) || (n_delay != '0);
        n_out.read_word = n_recv;
        n_out.read_done = w_done;
        n_out.rejected  = i_item.is_cmd && w_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_bits      <= '0;
            r_send      <= '0;
            r_recv      <= '0;
            r_delay     <= '0;
            r_kind      <= KIND_TICK;
            r_clk       <= 1'b0;
            r_dat       <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_step  <= n_step;
                r_bits  <= n_bits;
                r_send  <= n_send;
                r_recv  <= n_recv;
                r_delay <= n_delay;
                r_kind  <= n_kind;
                r_clk   <= n_clk;
                r_dat   <= n_dat;
                r_sel   <= n_sel;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/microwire_eeprom_master.sv @@
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser kind, tdata addr/word/serial_in
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata pins, busy, read word, flags
// apb       | in  | psel/penable/pready          | 8 registers at 4*i
//
// One item per clock sustained unless m_axis stalls; each item is one timing tick of the
// pin sequencer. Items pass a command queue stage, then the sequencer step into the
// output register. Reset is synchronous: pins low, sequencer idle, registers at defaults.
// A stalled m_axis holds the sequencer; the queue then fills and drops s_axis_tready.
module microwire_eeprom_master #(
    parameter int FRAME_BITS_MAX = mwee_pkg::FRAME_BITS_MAX_DEF,
    parameter int READ_BITS      = mwee_pkg::READ_BITS_DEF,
    parameter int QUEUE_DEPTH    = mwee_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [5:0] word_address, [21:6] write_word, [22] serial_in
    input  logic [mwee_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] clock_pin, [1] data_pin, [2] select_pin, [3] busy_res,
    // [19:4] read_word, [20] read_done, [21] rejected
    output logic [mwee_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mwee_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [mwee_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [mwee_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import mwee_pkg::*;

    t_cfg    r_cfg;
    t_cmd    w_push_item, w_head;
    t_qstat  w_qstat;
    t_result w_result;
    logic    w_push, w_pop, w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_op       <= RST_READ_OP;
            r_cfg.write_op      <= RST_WRITE_OP;
            r_cfg.enable_frame  <= RST_ENABLE;
            r_cfg.disable_frame <= RST_DISABLE;
            r_cfg.erase_frame   <= RST_ERASE;
            r_cfg.fill_frame    <= RST_FILL;
            r_cfg.edge_delay    <= RST_EDGE_DELAY;
            r_cfg.write_wait    <= RST_WRITE_WAIT;
        end else if (w_wr) begin
            case (w_idx)
                REG_READ_OP:    r_cfg.read_op       <= pwdata[8:0];
                REG_WRITE_OP:   r_cfg.write_op      <= pwdata[8:0];
                REG_ENABLE:     r_cfg.enable_frame  <= pwdata[8:0];
                REG_DISABLE:    r_cfg.disable_frame <= pwdata[8:0];
                REG_ERASE:      r_cfg.erase_frame   <= pwdata[8:0];
                REG_FILL:       r_cfg.fill_frame    <= pwdata[FILL_W-1:0];
                REG_EDGE_DELAY: r_cfg.edge_delay    <= pwdata[15:0];
                REG_WRITE_WAIT: r_cfg.write_wait    <= pwdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_READ_OP:    prdata = CFG_DATA_W'(r_cfg.read_op);
            REG_WRITE_OP:   prdata = CFG_DATA_W'(r_cfg.write_op);
            REG_ENABLE:     prdata = CFG_DATA_W'(r_cfg.enable_frame);
            REG_DISABLE:    prdata = CFG_DATA_W'(r_cfg.disable_frame);
            REG_ERASE:      prdata = CFG_DATA_W'(r_cfg.erase_frame);
            REG_FILL:       prdata = CFG_DATA_W'(r_cfg.fill_frame);
            REG_EDGE_DELAY: prdata = CFG_DATA_W'(r_cfg.edge_delay);
            REG_WRITE_WAIT: prdata = CFG_DATA_W'(r_cfg.write_wait);
            default:        prdata = '0;
        endcase
    end

    mwee_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    mwee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_stat  (w_qstat)
    );

    mwee_back #(
        .FRAME_BITS_MAX (FRAME_BITS_MAX),
        .READ_BITS      (READ_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (w_qstat),
        .i_item   (w_head),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_result (w_result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_result);

    a_clk_needs_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_result.clk |-> w_result.sel)
        else $error("serial clock high while chip select low");

    a_idle_pins_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_result.busy |-> !w_result.sel && !w_result.clk)
        else $error("pins not parked while idle");

    a_done_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_result.read_done |-> w_result.busy && w_result.sel
            && !w_result.clk)
        else $error("read completion outside a selected frame");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.empty |-> s_axis_tready && !w_pop)
        else $error("empty queue refused input or was popped");

endmodule
